[hdl/stsu_pkg.sv]
package stsu_pkg;

  localparam int SLOTS       = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
  localparam int ORD_D       = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
  localparam int ORD_W       = (ORD_D > 1) ? $clog2(ORD_D) : 1;

  typedef enum logic [2:0] {
    OP_SCHEDULE = 3'd0,
    OP_CANCEL   = 3'd1,
    OP_EXECUTE  = 3'd2,
    OP_TICK     = 3'd3,
    OP_SHUTDOWN = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_SCHED_ACK  = 2'd0,
    KIND_CANCEL_ACK = 2'd1,
    KIND_FIRE       = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [30:0] now;
    logic [30:0] delay;
    logic        periodic;
    logic        urgent;
    logic [31:0] task_id_in;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] task_id;
    logic        ok;
    logic        last;
    logic [5:0]  live_count;
  } out_item_t;

  // One timer entry as held in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [32:0] deadline;
    logic [30:0] period;
  } mem_word_t;

  // Candidate presented to the picker, one slot per cycle
  typedef struct packed {
    logic             en;
    logic             elig;
    logic             match;
    logic [IDX_W-1:0] idx;
    logic             urg;
  } eval_t;

  typedef struct packed {
    logic             have;
    logic [IDX_W-1:0] idx;
    logic             urg;
    logic [31:0]      age;
    mem_word_t        word;
  } best_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    mem_word_t        word;
  } found_t;

endpackage

[hdl/stsu_ram.sv]
module stsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/stsu_pick.sv]
module stsu_pick (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  stsu_pkg::eval_t     ev,
  input  stsu_pkg::mem_word_t word,
  input  logic [31:0]         next_id,
  output stsu_pkg::best_t     best,
  output stsu_pkg::found_t    fnd
);

  stsu_pkg::best_t  best_r;
  stsu_pkg::found_t fnd_r;
  logic [31:0]      age;
  logic             better;

  // Urgent class first, then the larger age (older id)
  always_comb begin
    age = next_id - word.id;
    if (ev.urg != best_r.urg) begin
      better = ev.urg;
    end else begin
      better = age > best_r.age;
    end
  end

  // Track the best eligible slot and the lowest matching slot of a sweep
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      best_r.have <= 1'b0;
      fnd_r.hit   <= 1'b0;
    end else if (ev.en) begin
      if (ev.elig && (!best_r.have || better)) begin
        best_r.have <= 1'b1;
        best_r.idx  <= ev.idx;
        best_r.urg  <= ev.urg;
        best_r.age  <= age;
        best_r.word <= word;
      end
      if (ev.match && !fnd_r.hit) begin
        fnd_r.hit  <= 1'b1;
        fnd_r.idx  <= ev.idx;
        fnd_r.word <= word;
      end
    end
  end

  assign best = best_r;
  assign fnd  = fnd_r;

endmodule

[hdl/software_timer_scheduler_unit.sv]
// Software timer table of stsu_pkg::SLOTS entries. Schedule and unknown ops give their
// single result in the cycle after start and the next item is taken right away. Cancel
// and execute sweep the slot memory once. A tick or shutdown that fires F entries runs
// F+1 sweeps (one slot read per cycle through the single memory read port), then
// streams the F fire results back to back. Results appear on out_item for one cycle,
// marked by out_valid; the receiver cannot stall, and busy stays high until the
// last result.
module software_timer_scheduler_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  stsu_pkg::in_item_t  in_item,
  output logic                out_valid,
  output stsu_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DECIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  localparam int IW = stsu_pkg::IDX_W;
  localparam int CW = stsu_pkg::CNT_W;
  localparam int NW = stsu_pkg::NUM_W;
  localparam int OW = stsu_pkg::ORD_W;
  localparam int S  = stsu_pkg::SLOTS;

  state_t                state_r, state_nxt;
  stsu_pkg::in_item_t    item_r, item_nxt;
  logic [31:0]           next_id_r, next_id_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [S-1:0]          valid_r, valid_nxt;
  logic [S-1:0]          per_r, per_nxt;
  logic [S-1:0]          urg_r, urg_nxt;
  logic [S-1:0]          mark_r, mark_nxt;
  logic [S-1:0]          fired_r, fired_nxt;
  logic [CW-1:0]         addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [NW-1:0]         k_r, k_nxt;
  logic [IW-1:0]         order_r [stsu_pkg::ORD_D];
  logic [IW-1:0]         order_nxt [stsu_pkg::ORD_D];
  stsu_pkg::out_item_t   out_r, out_nxt;
  logic                  out_vld_r, out_vld_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  stsu_pkg::mem_word_t   ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [$bits(stsu_pkg::mem_word_t)-1:0] ram_rdata;
  stsu_pkg::mem_word_t   rd_word;

  logic                  pick_clr;
  stsu_pkg::eval_t       ev;
  stsu_pkg::best_t       best;
  stsu_pkg::found_t      fnd;

  logic                  free_hit;
  logic [IW-1:0]         free_idx;
  logic [S-1:0]          keep;
  logic [CW-1:0]         keep_count;

  stsu_ram #(
    .WIDTH($bits(stsu_pkg::mem_word_t)),
    .DEPTH(S)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word = ram_rdata;

  stsu_pick u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (pick_clr),
    .ev      (ev),
    .word    (rd_word),
    .next_id (next_id_r),
    .best    (best),
    .fnd     (fnd)
  );

  // Find the lowest free slot
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_hit = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Drop marked entries and fired one-shot entries after a tick
  assign keep       = valid_r & ~mark_r & ~(fired_r & ~per_r);
  assign keep_count = CW'($countones(keep));

  // Present the slot read last cycle to the picker
  always_comb begin
    ev.en    = rd_vld_r && (state_r == S_SWEEP);
    ev.idx   = rd_idx_r;
    ev.urg   = urg_r[rd_idx_r];
    ev.elig  = valid_r[rd_idx_r] && !fired_r[rd_idx_r] && !mark_r[rd_idx_r] &&
               ((item_r.op == stsu_pkg::OP_SHUTDOWN) ||
                ({2'b00, item_r.now} >= rd_word.deadline));
    ev.match = valid_r[rd_idx_r] && (rd_word.id == item_r.task_id_in);
  end

  // Sequence the sweeps, updates and result stream
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    next_id_nxt = next_id_r;
    count_nxt   = count_r;
    valid_nxt   = valid_r;
    per_nxt     = per_r;
    urg_nxt     = urg_r;
    mark_nxt    = mark_r;
    fired_nxt   = fired_r;
    addr_nxt    = addr_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    order_nxt   = order_r;
    out_nxt     = out_r;
    out_vld_nxt = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    pick_clr    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          priority if (in_item.op == stsu_pkg::OP_SCHEDULE) begin
            next_id_nxt = next_id_r + 32'd1;
            if (free_hit) begin
              ram_we             = 1'b1;
              ram_waddr          = free_idx;
              ram_wdata.id       = next_id_nxt;
              ram_wdata.deadline = 33'(in_item.now) + 33'(in_item.delay);
              ram_wdata.period   = in_item.delay;
              valid_nxt[free_idx] = 1'b1;
              per_nxt[free_idx]   = in_item.periodic;
              urg_nxt[free_idx]   = in_item.urgent;
              mark_nxt[free_idx]  = 1'b0;
              count_nxt           = count_r + CW'(1);
            end
            out_vld_nxt         = 1'b1;
            out_nxt.result_kind = stsu_pkg::KIND_SCHED_ACK;
            out_nxt.task_id     = next_id_nxt;
            out_nxt.ok          = free_hit;
            out_nxt.last        = 1'b1;
            out_nxt.live_count  = 6'(count_nxt);
          end else if (in_item.op == stsu_pkg::OP_CANCEL ||
                       in_item.op == stsu_pkg::OP_EXECUTE ||
                       in_item.op == stsu_pkg::OP_TICK ||
                       in_item.op == stsu_pkg::OP_SHUTDOWN) begin
            state_nxt = S_SWEEP;
            addr_nxt  = '0;
            pick_clr  = 1'b1;
            n_nxt     = '0;
            fired_nxt = '0;
          end else begin
            out_vld_nxt         = 1'b1;
            out_nxt.result_kind = stsu_pkg::KIND_NONE;
            out_nxt.task_id     = '0;
            out_nxt.ok          = 1'b0;
            out_nxt.last        = 1'b1;
            out_nxt.live_count  = 6'(count_r);
          end
        end
      end

      S_SWEEP: begin
        if (addr_r < CW'(S)) begin
          ram_raddr  = addr_r[IW-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = addr_r[IW-1:0];
          addr_nxt   = addr_r + CW'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        priority if (item_r.op == stsu_pkg::OP_CANCEL) begin
          if (fnd.hit) begin
            mark_nxt[fnd.idx] = 1'b1;
          end
          out_vld_nxt         = 1'b1;
          out_nxt.result_kind = stsu_pkg::KIND_CANCEL_ACK;
          out_nxt.task_id     = item_r.task_id_in;
          out_nxt.ok          = fnd.hit;
          out_nxt.last        = 1'b1;
          out_nxt.live_count  = 6'(count_r);
          state_nxt           = S_IDLE;
        end else if (item_r.op == stsu_pkg::OP_EXECUTE) begin
          if (fnd.hit) begin
            ram_we             = 1'b1;
            ram_waddr          = fnd.idx;
            ram_wdata.id       = fnd.word.id;
            ram_wdata.deadline = '0;
            ram_wdata.period   = fnd.word.period;
          end
          out_vld_nxt         = 1'b1;
          out_nxt.result_kind = fnd.hit ? stsu_pkg::KIND_FIRE : stsu_pkg::KIND_NONE;
          out_nxt.task_id     = item_r.task_id_in;
          out_nxt.ok          = fnd.hit;
          out_nxt.last        = 1'b1;
          out_nxt.live_count  = 6'(count_r);
          state_nxt           = S_IDLE;
        end else begin
          if (best.have && (n_r < NW'(stsu_pkg::MAX_RESULTS))) begin
            // Fire the winner, re-arm it on a tick if periodic, and sweep again
            fired_nxt[best.idx]    = 1'b1;
            order_nxt[n_r[OW-1:0]] = best.idx;
            n_nxt                  = n_r + NW'(1);
            if ((item_r.op == stsu_pkg::OP_TICK) && per_r[best.idx]) begin
              ram_we             = 1'b1;
              ram_waddr          = best.idx;
              ram_wdata.id       = best.word.id;
              ram_wdata.deadline = 33'(item_r.now) + 33'(best.word.period);
              ram_wdata.period   = best.word.period;
            end
            state_nxt = S_SWEEP;
            addr_nxt  = '0;
            pick_clr  = 1'b1;
          end else begin
            if (item_r.op == stsu_pkg::OP_SHUTDOWN) begin
              valid_nxt = '0;
              count_nxt = '0;
            end else begin
              valid_nxt = keep;
              count_nxt = keep_count;
            end
            if (n_r == '0) begin
              out_vld_nxt         = 1'b1;
              out_nxt.result_kind = stsu_pkg::KIND_NONE;
              out_nxt.task_id     = '0;
              out_nxt.ok          = 1'b0;
              out_nxt.last        = 1'b1;
              out_nxt.live_count  = 6'(count_nxt);
              state_nxt           = S_IDLE;
            end else begin
              k_nxt     = '0;
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_EMIT: begin
        if (k_r < n_r) begin
          ram_raddr  = order_r[k_r[OW-1:0]];
          rd_vld_nxt = 1'b1;
          k_nxt      = k_r + NW'(1);
        end
        if (rd_vld_r) begin
          out_vld_nxt         = 1'b1;
          out_nxt.result_kind = stsu_pkg::KIND_FIRE;
          out_nxt.task_id     = rd_word.id;
          out_nxt.ok          = 1'b1;
          out_nxt.last        = (k_r == n_r);
          out_nxt.live_count  = 6'(count_r);
          if (k_r == n_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      next_id_r <= '0;
      count_r   <= '0;
      valid_r   <= '0;
      fired_r   <= '0;
      rd_vld_r  <= 1'b0;
      n_r       <= '0;
      k_r       <= '0;
      addr_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      next_id_r <= next_id_nxt;
      count_r   <= count_nxt;
      valid_r   <= valid_nxt;
      fired_r   <= fired_nxt;
      rd_vld_r  <= rd_vld_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      addr_r    <= addr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    per_r    <= per_nxt;
    urg_r    <= urg_nxt;
    mark_r   <= mark_nxt;
    rd_idx_r <= rd_idx_nxt;
    order_r  <= order_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // The live count always matches the occupied slots between items
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r == CW'($countones(valid_r))))
    else $error("live count differs from occupied slots");

  // Each fire recorded in the order list marks exactly one slot
  a_fired_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (NW'($countones(fired_r)) == n_r))
    else $error("fired slots differ from fire count");

  // The final streamed fire closes the item
  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && rd_vld_r && k_r == n_r) |=>
      (out_valid && out_item.last && state_r == S_IDLE))
    else $error("last fire not flagged");

endmodule
